>>> design/rope_pkg.sv
// ============================================================================
// rope_pkg
// Shared constants, types and half-precision arithmetic helpers for the
// rotary position embedding datapath.
// ============================================================================
package rope_pkg;

    localparam int DEF_MAX_PAIRS = 128;

    localparam logic [7:0] PAIR_CNT_RST = 8'd64;
    localparam logic       ILV_RST      = 1'b0;

    // Configuration register indexes.
    localparam logic CFG_PAIR_CNT = 1'b0;
    localparam logic CFG_ILV_MODE = 1'b1;

    localparam logic [15:0] HALF_QNAN = 16'h7E00;
    localparam logic [15:0] HALF_INF  = 16'h7C00;

    // Fixed-point frame: bit 0 weighs 2^-27 and also carries the sticky jam.
    localparam int FRAC_BITS = 27;
    localparam int PW        = 45;          // product frame, values below 2^18
    localparam int FW        = PW + 1;      // sum frame

    typedef struct packed {
        logic          big;                 // value is 2^18 or more
        logic [PW-1:0] v;
    } t_frame;

    typedef struct packed {
        logic          spec;                // special-case result in sval
        logic [15:0]   sval;
        logic          sg;
        logic [FW-1:0] m;
    } t_fma;

    function automatic logic f_is_nan(input logic [15:0] h);
        return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    endfunction

    function automatic logic f_is_inf(input logic [15:0] h);
        return h[14:0] == 15'h7C00;
    endfunction

    function automatic logic f_is_zero(input logic [15:0] h);
        return h[14:0] == 15'd0;
    endfunction

    function automatic logic [10:0] f_mant(input logic [15:0] h);
        return {(h[14:10] != 5'd0), h[9:0]};
    endfunction

    function automatic logic signed [7:0] f_exp(input logic [15:0] h);
        logic signed [7:0] e;
        if (h[14:10] == 5'd0) begin
            e = -8'sd24;
        end else begin
            e = $signed({3'b000, h[14:10]}) - 8'sd25;
        end
        return e;
    endfunction

    // Places m * 2^e into the frame, jamming lost low bits into bit 0.
    function automatic t_frame f_frame(input logic [21:0] m, input logic signed [7:0] e);
        t_frame            f;
        logic signed [7:0] sh;
        logic [63:0]       t;
        logic [21:0]       rt;
        logic [21:0]       mask;
        logic [4:0]        n;
        sh = e + 8'sd27;
        if (sh >= 0) begin
            t   = {42'd0, m} << sh[5:0];
            f.big = |t[63:PW];
            f.v   = t[PW-1:0];
        end else begin
            n     = 5'(-sh);
            rt    = m >> n;
            mask  = (22'd1 << n) - 22'd1;
            f.big = 1'b0;
            f.v   = {23'd0, rt[21:1], rt[0] | (|(m & mask))};
        end
        return f;
    endfunction

    // Rounds a frame value to half precision, nearest even, gradual underflow.
    function automatic logic [15:0] f_round(input logic sgn, input logic [FW-1:0] v);
        logic [5:0]    lead;
        logic [5:0]    s;
        logic [FW-1:0] sh;
        logic [FW-1:0] mask;
        logic [11:0]   r;
        logic          g;
        logic          st;
        logic [6:0]    field;
        logic [15:0]   res;
        lead = 6'd0;
        for (int i = 0; i < FW; i++) begin
            if (v[i]) lead = 6'(i);
        end
        s    = (lead >= 6'd13) ? lead - 6'd10 : 6'd3;
        sh   = v >> s;
        r    = {1'b0, sh[10:0]};
        g    = v[s - 6'd1];
        mask = (FW'(1) << (s - 6'd1)) - FW'(1);
        st   = |(v & mask);
        if (g && (st || r[0])) r = r + 12'd1;
        if (r[11]) begin
            r = r >> 1;
            s = s + 6'd1;
        end
        field = {1'b0, s} - 7'd2;
        if (v == '0) begin
            res = {sgn, 15'd0};
        end else if (!r[10]) begin
            res = {sgn, 5'd0, r[9:0]};
        end else if (field >= 7'd31) begin
            res = {sgn, HALF_INF[14:0]};
        end else begin
            res = {sgn, field[4:0], r[9:0]};
        end
        return res;
    endfunction

    // Final half product from the operands and the framed exact product.
    function automatic logic [15:0] f_hmul(input logic [15:0] a, input logic [15:0] b,
                                           input t_frame p);
        logic        sg;
        logic [15:0] res;
        sg = a[15] ^ b[15];
        if (f_is_nan(a) || f_is_nan(b)) begin
            res = HALF_QNAN;
        end else if ((f_is_inf(a) && f_is_zero(b)) || (f_is_inf(b) && f_is_zero(a))) begin
            res = HALF_QNAN;
        end else if (f_is_inf(a) || f_is_inf(b) || p.big) begin
            res = {sg, HALF_INF[14:0]};
        end else begin
            res = f_round(sg, {1'b0, p.v});
        end
        return res;
    endfunction

    // Aligned add of a and +/- b*c, with q the framed exact b*c.
    function automatic t_fma f_fma(input logic [15:0] a, input logic [15:0] b,
                                   input logic [15:0] c, input logic neg, input t_frame q);
        t_fma          r;
        t_frame        fa;
        logic          sa;
        logic          ps;
        logic [FW-1:0] av;
        logic [FW-1:0] pv;
        sa     = a[15];
        ps     = b[15] ^ c[15] ^ neg;
        fa     = f_frame({11'd0, f_mant(a)}, f_exp(a));
        av     = {1'b0, fa.v};
        pv     = {1'b0, q.v};
        r.spec = 1'b1;
        r.sval = 16'd0;
        r.sg   = 1'b0;
        r.m    = '0;
        if (f_is_nan(a) || f_is_nan(b) || f_is_nan(c)) begin
            r.sval = HALF_QNAN;
        end else if ((f_is_inf(b) && f_is_zero(c)) || (f_is_inf(c) && f_is_zero(b))) begin
            r.sval = HALF_QNAN;
        end else if (f_is_inf(b) || f_is_inf(c)) begin
            r.sval = (f_is_inf(a) && (sa != ps)) ? HALF_QNAN : {ps, HALF_INF[14:0]};
        end else if (f_is_inf(a)) begin
            r.sval = a;
        end else if (f_is_zero(b) || f_is_zero(c)) begin
            r.sval = f_is_zero(a) ? {sa & ps, 15'd0} : a;
        end else if (q.big) begin
            r.sval = {ps, HALF_INF[14:0]};
        end else begin
            r.spec = 1'b0;
            if (sa == ps) begin
                r.m  = av + pv;
                r.sg = sa;
            end else if (av >= pv) begin
                r.m  = av - pv;
                r.sg = sa;
            end else begin
                r.m  = pv - av;
                r.sg = ps;
            end
        end
        return r;
    endfunction

endpackage

>>> design/rope_in_if.sv
// ============================================================================
// rope_in_if
// Element channel: one vector element with the sine and cosine of its pair.
// ============================================================================
interface rope_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] element;
    logic [15:0] sin_value;
    logic [15:0] cos_value;

    modport source (output valid, element, sin_value, cos_value, input ready);
    modport sink   (input valid, element, sin_value, cos_value, output ready);
endinterface

>>> design/rope_out_if.sv
// ============================================================================
// rope_out_if
// Result channel: one rotated element with its position and run markers.
// ============================================================================
interface rope_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_value;
    logic [7:0]  out_position;
    logic        run_end;
    logic        vector_end;

    modport source (output valid, out_value, out_position, run_end, vector_end, input ready);
    modport sink   (input valid, out_value, out_position, run_end, vector_end, output ready);
endinterface

>>> design/rope_ram.sv
// ============================================================================
// rope_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ============================================================================
module rope_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/rotary_embedding_fp16.sv
// ============================================================================
// rotary_embedding_fp16
// Streaming rotary position embedding on half-precision vector elements.
// ============================================================================
// Result order: the real result of a pair passes through the pipeline stages and
// the output pair buffer; the imaginary result follows once the real one is taken.
// Throughput: one element per cycle while results are taken, in interleaved mode
// and in the first half of a split vector; in the second half each element yields
// two results through the one result port, so an element waits for both to leave.
// Reset clears the element position and loads the default configuration; the
// real-part store is not cleared, every entry is written before it is read.
// ============================================================================
module rotary_embedding_fp16
    import rope_pkg::*;
#(
    parameter int MAX_PAIRS = DEF_MAX_PAIRS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [7:0]      i_cfg_data,
    rope_in_if.sink         i_elem_ch,
    rope_out_if.source      o_rot_ch
);
    // The real parts of the pairs live in a RAM addressed by pair number. A
    // non-completing element is written there; the completing element reads
    // its partner back when it is accepted. In interleaved mode the read of an
    // entry comes at a later edge than its write, so the read already sees
    // the new data and no forwarding is needed.
    localparam int         AW    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam logic [7:0] PLIM  = 8'((MAX_PAIRS < 128) ? MAX_PAIRS : 128);
    localparam logic [7:0] KMAX  = PLIM - 8'd1;

    // Configuration and sequencing.
    logic [7:0]  r_pair_cnt;
    logic        r_ilv;
    logic [7:0]  r_idx;
    logic [7:0]  n_idx;

    logic [7:0]  w_p;
    logic [8:0]  w_total;
    logic [7:0]  w_cur;
    logic [8:0]  w_inc;
    logic        w_complete;
    logic [7:0]  w_k;
    logic [7:0]  w_pos_r;
    logic        w_vend;
    logic [AW-1:0] w_addr;

    logic        w_ob_load;
    logic        w_adv;
    logic        w_accept;
    logic [15:0] w_re;

    // Pipeline stage 1: element accepted, real part being read.
    logic        r_s1_vld;
    logic [15:0] r_s1_elem, r_s1_sin, r_s1_cos;
    logic [7:0]  r_s1_pos_r, r_s1_pos_i;
    logic        r_s1_vend;

    // Stage 2: exact mantissa products.
    logic        r_s2_vld;
    logic [15:0] r_s2_re, r_s2_elem, r_s2_sin, r_s2_cos;
    logic [21:0] r_s2_pc, r_s2_ps, r_s2_qs, r_s2_qc;
    logic [7:0]  r_s2_pos_r, r_s2_pos_i;
    logic        r_s2_vend;

    // Stage 3: products aligned into the fixed-point frame.
    logic        r_s3_vld;
    logic [15:0] r_s3_re, r_s3_elem, r_s3_sin, r_s3_cos;
    t_frame      r_s3_pc, r_s3_ps, r_s3_qs, r_s3_qc;
    logic [7:0]  r_s3_pos_r, r_s3_pos_i;
    logic        r_s3_vend;

    // Stage 4: rounded real*cos and real*sin.
    logic        r_s4_vld;
    logic [15:0] r_s4_ac, r_s4_as, r_s4_elem, r_s4_sin, r_s4_cos;
    t_frame      r_s4_qs, r_s4_qc;
    logic [7:0]  r_s4_pos_r, r_s4_pos_i;
    logic        r_s4_vend;

    // Stage 5: fused sums before final rounding.
    logic        r_s5_vld;
    t_fma        r_s5_real, r_s5_imag;
    logic [7:0]  r_s5_pos_r, r_s5_pos_i;
    logic        r_s5_vend;

    // Output pair buffer: sends the real result, then the imaginary one.
    logic        r_ob_vld;
    logic        r_ob_sel;
    logic [15:0] r_ob_real, r_ob_imag;
    logic [7:0]  r_ob_pos_r, r_ob_pos_i;
    logic        r_ob_vend;

    logic [15:0] w_res_real, w_res_imag;

    // Effective pair count: zero acts as one, large counts saturate.
    always_comb begin
        if (r_pair_cnt == 8'd0) begin
            w_p = 8'd1;
        end else if (r_pair_cnt > PLIM) begin
            w_p = PLIM;
        end else begin
            w_p = r_pair_cnt;
        end
        w_total = {w_p, 1'b0};
        w_cur   = ({1'b0, r_idx} >= w_total) ? 8'd0 : r_idx;
        w_inc   = {1'b0, w_cur} + 9'd1;
        if (r_ilv) begin
            w_complete = w_cur[0];
            w_k        = {1'b0, w_cur[7:1]};
            w_pos_r    = w_cur - 8'd1;
        end else begin
            w_complete = (w_cur >= w_p);
            w_k        = w_complete ? (w_cur - w_p) : w_cur;
            w_pos_r    = w_k;
        end
        if (w_k > KMAX) w_k = KMAX;
        if (!r_ilv) w_pos_r = w_k;
        w_vend = (w_inc == w_total);
        n_idx  = (w_inc >= w_total) ? 8'd0 : w_inc[7:0];
        w_addr = AW'(w_k);
    end

    // The output buffer takes a new pair when it is empty or is handing over
    // its second result in this cycle. The pipeline moves whenever the buffer
    // takes a pair or the last stage holds a bubble, so a pending result does
    // not hold up elements that produce nothing.
    assign w_ob_load = !r_ob_vld || (r_ob_sel && o_rot_ch.ready);
    assign w_adv     = w_ob_load || !r_s5_vld;
    assign w_accept  = i_elem_ch.valid && w_adv;
    assign i_elem_ch.ready = w_adv;

    rope_ram #(
        .WIDTH (16),
        .DEPTH (MAX_PAIRS)
    ) u_real_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && !w_complete),
        .i_waddr (w_addr),
        .i_wdata (i_elem_ch.element),
        .i_re    (w_accept && w_complete),
        .i_raddr (w_addr),
        .o_rdata (w_re)
    );

    // Configuration writes restart the vector.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_cnt <= PAIR_CNT_RST;
            r_ilv      <= ILV_RST;
            r_idx      <= 8'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_PAIR_CNT) begin
                r_pair_cnt <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_ILV_MODE) begin
                r_ilv <= i_cfg_data[0];
            end
            r_idx <= 8'd0;
        end else if (w_accept) begin
            r_idx <= n_idx;
        end
    end

    // Control state of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_ob_vld <= 1'b0;
            r_ob_sel <= 1'b0;
        end else begin
            if (w_adv) begin
                r_s1_vld <= w_accept && w_complete;
                r_s2_vld <= r_s1_vld;
                r_s3_vld <= r_s2_vld;
                r_s4_vld <= r_s3_vld;
                r_s5_vld <= r_s4_vld;
            end
            if (w_ob_load) begin
                r_ob_vld <= r_s5_vld;
                r_ob_sel <= 1'b0;
            end else if (r_ob_vld && o_rot_ch.ready) begin
                r_ob_sel <= 1'b1;
            end
        end
    end

    assign w_res_real = r_s5_real.spec ? r_s5_real.sval :
                        (r_s5_real.m == '0) ? 16'd0 : f_round(r_s5_real.sg, r_s5_real.m);
    assign w_res_imag = r_s5_imag.spec ? r_s5_imag.sval :
                        (r_s5_imag.m == '0) ? 16'd0 : f_round(r_s5_imag.sg, r_s5_imag.m);

    // Datapath registers, advancing together with the control state.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_elem  <= i_elem_ch.element;
            r_s1_sin   <= i_elem_ch.sin_value;
            r_s1_cos   <= i_elem_ch.cos_value;
            r_s1_pos_r <= w_pos_r;
            r_s1_pos_i <= w_cur;
            r_s1_vend  <= w_vend;

            r_s2_re    <= w_re;
            r_s2_elem  <= r_s1_elem;
            r_s2_sin   <= r_s1_sin;
            r_s2_cos   <= r_s1_cos;
            r_s2_pc    <= f_mant(w_re) * f_mant(r_s1_cos);
            r_s2_ps    <= f_mant(w_re) * f_mant(r_s1_sin);
            r_s2_qs    <= f_mant(r_s1_elem) * f_mant(r_s1_sin);
            r_s2_qc    <= f_mant(r_s1_elem) * f_mant(r_s1_cos);
            r_s2_pos_r <= r_s1_pos_r;
            r_s2_pos_i <= r_s1_pos_i;
            r_s2_vend  <= r_s1_vend;

            r_s3_re    <= r_s2_re;
            r_s3_elem  <= r_s2_elem;
            r_s3_sin   <= r_s2_sin;
            r_s3_cos   <= r_s2_cos;
            r_s3_pc    <= f_frame(r_s2_pc, f_exp(r_s2_re) + f_exp(r_s2_cos));
            r_s3_ps    <= f_frame(r_s2_ps, f_exp(r_s2_re) + f_exp(r_s2_sin));
            r_s3_qs    <= f_frame(r_s2_qs, f_exp(r_s2_elem) + f_exp(r_s2_sin));
            r_s3_qc    <= f_frame(r_s2_qc, f_exp(r_s2_elem) + f_exp(r_s2_cos));
            r_s3_pos_r <= r_s2_pos_r;
            r_s3_pos_i <= r_s2_pos_i;
            r_s3_vend  <= r_s2_vend;

            r_s4_ac    <= f_hmul(r_s3_re, r_s3_cos, r_s3_pc);
            r_s4_as    <= f_hmul(r_s3_re, r_s3_sin, r_s3_ps);
            r_s4_elem  <= r_s3_elem;
            r_s4_sin   <= r_s3_sin;
            r_s4_cos   <= r_s3_cos;
            r_s4_qs    <= r_s3_qs;
            r_s4_qc    <= r_s3_qc;
            r_s4_pos_r <= r_s3_pos_r;
            r_s4_pos_i <= r_s3_pos_i;
            r_s4_vend  <= r_s3_vend;

            // Real part subtracts elem*sin, imaginary part adds elem*cos.
            r_s5_real  <= f_fma(r_s4_ac, r_s4_elem, r_s4_sin, 1'b1, r_s4_qs);
            r_s5_imag  <= f_fma(r_s4_as, r_s4_elem, r_s4_cos, 1'b0, r_s4_qc);
            r_s5_pos_r <= r_s4_pos_r;
            r_s5_pos_i <= r_s4_pos_i;
            r_s5_vend  <= r_s4_vend;
        end
        if (w_ob_load) begin
            r_ob_real  <= w_res_real;
            r_ob_imag  <= w_res_imag;
            r_ob_pos_r <= r_s5_pos_r;
            r_ob_pos_i <= r_s5_pos_i;
            r_ob_vend  <= r_s5_vend;
        end
    end

    assign o_rot_ch.valid        = r_ob_vld;
    assign o_rot_ch.out_value    = r_ob_sel ? r_ob_imag : r_ob_real;
    assign o_rot_ch.out_position = r_ob_sel ? r_ob_pos_i : r_ob_pos_r;
    assign o_rot_ch.run_end      = r_ob_sel;
    assign o_rot_ch.vector_end   = r_ob_sel && r_ob_vend;
endmodule
